/* src/lscf_pkg.sv */
// ----------------------------------------------------------------------------
// lscf_pkg: shared types and constants of the stored-chunk framer
// Chunk limits, frame byte codes, CRC-32 step and the command word that
// travels from the classifier to the byte sequencer.
// ----------------------------------------------------------------------------
package lscf_pkg;

  localparam int unsigned CHUNK_MAX  = 65536;
  localparam int unsigned RUN_W      = $clog2(CHUNK_MAX + 1);
  localparam int unsigned BLOCK_W    = 32;
  localparam int unsigned SIZE_W     = 33;
  localparam int unsigned OUT_DATA_W = ((8 + SIZE_W + 7) / 8) * 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0]  CTRL_STORED = 8'h01;
  localparam logic [7:0]  CTRL_END    = 8'h00;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

  // One accepted input byte, classified
  typedef struct packed {
    logic [7:0]        data;
    logic              hdr;   // chunk header goes ahead of the byte
    logic [15:0]       code;  // run length minus one
    logic              last;  // byte closes the block
    logic [1:0]        pad;   // zero bytes before the CRC
    logic [31:0]       crc;   // final CRC, already inverted
    logic [SIZE_W-1:0] size;  // chunk bytes plus end byte
  } cmd_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* src/lscf_front.sv */
// ----------------------------------------------------------------------------
// lscf_front: input classifier
// Tracks block and chunk counts and the running CRC, and turns each accepted
// byte into a command for the byte sequencer.
// ----------------------------------------------------------------------------
module lscf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_data_i,
  input  logic [lscf_pkg::BLOCK_W-1:0]  block_length_i,
  output logic                          cmd_valid_o,
  output lscf_pkg::cmd_t                cmd_o,
  input  logic                          cmd_ready_i
);
  import lscf_pkg::*;

  logic [BLOCK_W-1:0] bytes_left_q, bytes_left_d;
  logic [RUN_W-1:0]   chunk_left_q, chunk_left_d;
  logic [31:0]        crc_q, crc_d;
  logic [SIZE_W-1:0]  fcount_q, fcount_d;

  logic               start, hdr, last, accept;
  logic [BLOCK_W-1:0] bl_eff, bytes_cur, bytes_after;
  logic [RUN_W-1:0]   chunk_cur, run, run_m1, chunk_after;
  logic [31:0]        crc_cur, crc_new;
  logic [SIZE_W-1:0]  fc_cur, fc_after, size;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;

  always_comb begin
    bl_eff      = (block_length_i == '0) ? BLOCK_W'(1) : block_length_i;
    start       = (fcount_q == '0);
    bytes_cur   = start ? bl_eff : bytes_left_q;
    chunk_cur   = start ? '0 : chunk_left_q;
    crc_cur     = start ? CRC_INIT : crc_q;
    fc_cur      = start ? '0 : fcount_q;
    hdr         = (chunk_cur == '0);
    run         = (bytes_cur < BLOCK_W'(CHUNK_MAX)) ? bytes_cur[RUN_W-1:0] : RUN_W'(CHUNK_MAX);
    run_m1      = run - RUN_W'(1);
    chunk_after = (hdr ? run : chunk_cur) - RUN_W'(1);
    bytes_after = bytes_cur - BLOCK_W'(1);
    last        = (bytes_after == '0);
    fc_after    = fc_cur + (hdr ? SIZE_W'(4) : SIZE_W'(1));
    size        = fc_after + SIZE_W'(1);
    crc_new     = crc_byte(crc_cur, in_data_i);

    cmd_o.data = in_data_i;
    cmd_o.hdr  = hdr;
    cmd_o.code = run_m1[15:0];
    cmd_o.last = last;
    cmd_o.pad  = 2'(3'd4 - {1'b0, size[1:0]});
    cmd_o.crc  = ~crc_new;
    cmd_o.size = size;

    bytes_left_d = bytes_left_q;
    chunk_left_d = chunk_left_q;
    crc_d        = crc_q;
    fcount_d     = fcount_q;
    if (accept) begin
      if (last) begin
        // block closes: back to the idle state, next byte reloads
        bytes_left_d = bl_eff;
        chunk_left_d = '0;
        crc_d        = CRC_INIT;
        fcount_d     = '0;
      end else begin
        bytes_left_d = bytes_after;
        chunk_left_d = chunk_after;
        crc_d        = crc_new;
        fcount_d     = fc_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= BLOCK_W'(1);
      chunk_left_q <= '0;
      crc_q        <= CRC_INIT;
      fcount_q     <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      chunk_left_q <= chunk_left_d;
      crc_q        <= crc_d;
      fcount_q     <= fcount_d;
    end
  end

endmodule

/* src/lscf_fifo.sv */
// ----------------------------------------------------------------------------
// lscf_fifo: command queue
// Short queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module lscf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lscf_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output lscf_pkg::cmd_t pop_cmd_o
);
  import lscf_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      if (push && !pop)      count_q <= count_q + (FIFO_AW+1)'(1);
      else if (pop && !push) count_q <= count_q - (FIFO_AW+1)'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FIFO_AW'(wr_ptr_q - rd_ptr_q) == count_q[FIFO_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

/* src/lscf_back.sv */
// ----------------------------------------------------------------------------
// lscf_back: byte sequencer
// Walks each queued command through header, data and block trailer bytes
// and drives the output word register.
// ----------------------------------------------------------------------------
module lscf_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  lscf_pkg::cmd_t                       cmd_i,
  output logic                                 cmd_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lscf_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic                                 out_last_o,
  output logic                                 out_user_o
);
  import lscf_pkg::*;

  typedef enum logic [10:0] {
    S_START = 11'b000_0000_0001,
    S_HDR0  = 11'b000_0000_0010,
    S_HDR1  = 11'b000_0000_0100,
    S_HDR2  = 11'b000_0000_1000,
    S_DATA  = 11'b000_0001_0000,
    S_END   = 11'b000_0010_0000,
    S_PAD   = 11'b000_0100_0000,
    S_CRC0  = 11'b000_1000_0000,
    S_CRC1  = 11'b001_0000_0000,
    S_CRC2  = 11'b010_0000_0000,
    S_CRC3  = 11'b100_0000_0000
  } state_e;

  state_e            st_q, st_d, phase;
  logic [1:0]        pad_left_q, pad_left_d;
  logic              adv, done, blk_done;
  logic [7:0]        byte_d;

  logic              valid_q;
  logic [7:0]        byte_q;
  logic              last_q, user_q;
  logic [SIZE_W-1:0] size_q;

  assign adv = cmd_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    phase      = (st_q == S_START) ? (cmd_i.hdr ? S_HDR0 : S_DATA) : st_q;
    st_d       = st_q;
    pad_left_d = pad_left_q;
    byte_d     = 8'h00;
    done       = 1'b0;
    blk_done   = 1'b0;
    unique case (phase)
      S_HDR0: begin
        byte_d = CTRL_STORED;
        st_d   = S_HDR1;
      end
      S_HDR1: begin
        byte_d = cmd_i.code[15:8];
        st_d   = S_HDR2;
      end
      S_HDR2: begin
        byte_d = cmd_i.code[7:0];
        st_d   = S_DATA;
      end
      S_DATA: begin
        byte_d = cmd_i.data;
        if (cmd_i.last) begin
          st_d = S_END;
        end else begin
          done = 1'b1;
        end
      end
      S_END: begin
        byte_d     = CTRL_END;
        pad_left_d = cmd_i.pad;
        st_d       = (cmd_i.pad != 2'd0) ? S_PAD : S_CRC0;
      end
      S_PAD: begin
        byte_d     = 8'h00;
        pad_left_d = pad_left_q - 2'd1;
        st_d       = (pad_left_q == 2'd1) ? S_CRC0 : S_PAD;
      end
      S_CRC0: begin
        byte_d = cmd_i.crc[7:0];
        st_d   = S_CRC1;
      end
      S_CRC1: begin
        byte_d = cmd_i.crc[15:8];
        st_d   = S_CRC2;
      end
      S_CRC2: begin
        byte_d = cmd_i.crc[23:16];
        st_d   = S_CRC3;
      end
      S_CRC3: begin
        byte_d   = cmd_i.crc[31:24];
        done     = 1'b1;
        blk_done = 1'b1;
      end
      default: begin
        st_d = st_q;
      end
    endcase
    if (done) st_d = S_START;
  end

  assign cmd_pop_o = adv && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_START;
      pad_left_q <= 2'd0;
      valid_q    <= 1'b0;
    end else begin
      if (adv) begin
        st_q       <= st_d;
        pad_left_q <= pad_left_d;
        valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= byte_d;
      last_q <= done;
      user_q <= blk_done;
      size_q <= blk_done ? cmd_i.size : '0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {(OUT_DATA_W-8-SIZE_W)'(0), size_q, byte_q};
  assign out_last_o  = last_q;
  assign out_user_o  = user_q;

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && user_q |-> last_q)
    else $error("block end word without end of run");

  a_busy_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_START |-> cmd_valid_i)
    else $error("command left the queue before its bytes were sent");

  a_pop_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> valid_q && last_q)
    else $error("command retired without a closing word");

endmodule

/* src/lzma2_stored_chunk_framer_unit.sv */
// ----------------------------------------------------------------------------
// lzma2_stored_chunk_framer_unit: LZMA2 stored-chunk framer
// Frames a block of raw bytes as stored LZMA2 chunks, appends the end byte,
// padding to four bytes and the CRC-32 of the raw bytes.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata[7:0] data_byte
//  m_axis    out  tdata[7:0] out_byte, tdata[40:8] framed_size;
//                 tlast last_of_run; tuser block_done
//  cfg       in   cfg_wdata_i block_length, written on cfg_we_i
//
//  One output word per cycle while a command waits and m_axis_tready is high;
//  the single output register sets that pace. Header bytes precede a byte
//  opening a chunk; end byte, padding and CRC follow the block's last byte.
//  A four-entry command queue lets input bytes keep coming while header and
//  trailer bytes drain. Reset clears counts and the CRC; no clearing pass.
// ----------------------------------------------------------------------------
module lzma2_stored_chunk_framer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lscf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [7:0] out_byte,
                                                             // [40:8] framed_size
  output logic                                m_axis_tlast,  // last_of_run
  output logic                                m_axis_tuser,  // block_done
  input  logic                                cfg_we_i,
  input  logic [lscf_pkg::BLOCK_W-1:0]        cfg_wdata_i    // block_length
);
  import lscf_pkg::*;

  logic [BLOCK_W-1:0] block_length_q;
  logic               f_valid, f_ready, q_valid, q_pop;
  cmd_t               f_cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= BLOCK_W'(1);
    end else if (cfg_we_i) begin
      block_length_q <= cfg_wdata_i;
    end
  end

  lscf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_data_i      (s_axis_tdata),
    .block_length_i (block_length_q),
    .cmd_valid_o    (f_valid),
    .cmd_o          (f_cmd),
    .cmd_ready_i    (f_ready)
  );

  lscf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  lscf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

endmodule
